[src/buzzer_tone_sequencer_defines.svh]
// Assertion macros for the buzzer tone sequencer core.
`ifndef BUZZER_TONE_SEQUENCER_DEFINES_SVH
`define BUZZER_TONE_SEQUENCER_DEFINES_SVH

// Invariant checked at every clock edge out of reset.
`define BTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Implication: cons holds in the cycle after ante.
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bts_pkg.sv]
// Shared types, request codes and pattern ROM tables for the buzzer tone sequencer.
`timescale 1ns / 1ps

package bts_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_TONE  = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;
  localparam logic [1:0] REQ_START = 2'd3;

  localparam logic [3:0] PAT_HORN       = 4'd0;
  localparam logic [3:0] PAT_SIREN      = 4'd1;
  localparam logic [3:0] PAT_CHIRP      = 4'd2;
  localparam logic [3:0] PAT_CLICK      = 4'd3;
  localparam logic [3:0] PAT_HAPPY      = 4'd4;
  localparam logic [3:0] PAT_SAD        = 4'd5;
  localparam logic [3:0] PAT_SURPRISE   = 4'd6;
  localparam logic [3:0] PAT_DISCONNECT = 4'd7;
  localparam logic [3:0] PAT_BUTTON     = 4'd8;
  localparam logic [3:0] PAT_LAST       = PAT_BUTTON;

  localparam logic [4:0]  MAX_STEPS = 5'd20;
  localparam logic [15:0] HORN_STEP = 16'd40;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [15:0] tone_hz;
    logic [15:0] tone_ms;
    logic [3:0]  pattern_id;
    logic [15:0] repeat_count;
    logic [15:0] base_hz;
  } bts_req_t;

  typedef struct packed {
    logic [15:0] drive_hz;
    logic        sequence_busy;
  } bts_res_t;

  function automatic logic [4:0] pat_len(input logic [3:0] pat);
    unique case (pat)
      PAT_HORN:  return 5'd3;
      PAT_SIREN: return 5'd8;
      PAT_CHIRP: return 5'd20;
      PAT_CLICK: return 5'd1;
      default:   return 5'd3;
    endcase
  endfunction

  // Horn pitches come from the stored base, not from this table.
  function automatic logic [15:0] pat_freq(input logic [3:0] pat, input logic [4:0] idx);
    logic [15:0] f;
    f = 16'd0;
    unique case (pat)
      PAT_SIREN: f = idx[0] ? 16'd0 : 16'd1000;
      PAT_CHIRP: begin
        unique case (idx)
          5'd0:  f = 16'd1200;
          5'd1:  f = 16'd1400;
          5'd2:  f = 16'd1650;
          5'd3:  f = 16'd1950;
          5'd4:  f = 16'd2250;
          5'd6:  f = 16'd2100;
          5'd7:  f = 16'd1700;
          5'd8:  f = 16'd1300;
          5'd10: f = 16'd1000;
          5'd11: f = 16'd1250;
          5'd12: f = 16'd1500;
          5'd13: f = 16'd1750;
          5'd14: f = 16'd2100;
          5'd16: f = 16'd2300;
          5'd17: f = 16'd1800;
          5'd18: f = 16'd1400;
          5'd19: f = 16'd1100;
          default: f = 16'd0;
        endcase
      end
      PAT_CLICK: f = (idx == 5'd0) ? 16'd3000 : 16'd0;
      PAT_HAPPY: begin
        unique case (idx)
          5'd0:    f = 16'd800;
          5'd1:    f = 16'd1000;
          5'd2:    f = 16'd1300;
          default: f = 16'd0;
        endcase
      end
      PAT_SAD: f = (idx == 5'd0) ? 16'd700 : ((idx == 5'd2) ? 16'd500 : 16'd0);
      PAT_SURPRISE: begin
        unique case (idx)
          5'd0:    f = 16'd1200;
          5'd1:    f = 16'd1600;
          5'd2:    f = 16'd1000;
          default: f = 16'd0;
        endcase
      end
      PAT_DISCONNECT: f = (idx == 5'd0) ? 16'd900 : ((idx == 5'd2) ? 16'd700 : 16'd0);
      PAT_BUTTON: f = (idx == 5'd0 || idx == 5'd2) ? 16'd2500 : 16'd0;
      default: f = 16'd0;
    endcase
    return f;
  endfunction

  function automatic logic [15:0] pat_dur(input logic [3:0] pat, input logic [4:0] idx);
    logic [15:0] d;
    d = 16'd0;
    unique case (pat)
      PAT_HORN: d = (idx == 5'd1) ? 16'd120 : ((idx < 5'd3) ? 16'd350 : 16'd0);
      PAT_SIREN: d = (idx < 5'd8) ? 16'd200 : 16'd0;
      PAT_CHIRP: begin
        unique case (idx)
          5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd9, 5'd15: d = 16'd40;
          5'd4:                      d = 16'd60;
          5'd6, 5'd7:                d = 16'd50;
          5'd8, 5'd14:               d = 16'd70;
          5'd10, 5'd11, 5'd12, 5'd13: d = 16'd35;
          5'd16, 5'd17:              d = 16'd45;
          5'd18:                     d = 16'd55;
          5'd19:                     d = 16'd80;
          default:                   d = 16'd0;
        endcase
      end
      PAT_CLICK: d = (idx == 5'd0) ? 16'd30 : 16'd0;
      PAT_HAPPY: d = (idx == 5'd2) ? 16'd180 : ((idx < 5'd2) ? 16'd120 : 16'd0);
      PAT_SAD: begin
        unique case (idx)
          5'd0:    d = 16'd250;
          5'd1:    d = 16'd100;
          5'd2:    d = 16'd300;
          default: d = 16'd0;
        endcase
      end
      PAT_SURPRISE: begin
        unique case (idx)
          5'd0:    d = 16'd100;
          5'd1:    d = 16'd120;
          5'd2:    d = 16'd140;
          default: d = 16'd0;
        endcase
      end
      PAT_DISCONNECT: begin
        unique case (idx)
          5'd0:    d = 16'd180;
          5'd1:    d = 16'd100;
          5'd2:    d = 16'd220;
          default: d = 16'd0;
        endcase
      end
      PAT_BUTTON: begin
        unique case (idx)
          5'd0, 5'd2: d = 16'd30;
          5'd1:       d = 16'd40;
          default:    d = 16'd0;
        endcase
      end
      default: d = 16'd0;
    endcase
    return d;
  endfunction

endpackage

[src/bts_rom.sv]
// Pattern step lookup: pitch, step length and table length for one pattern step.
`timescale 1ns / 1ps

module bts_rom (
  input  logic [3:0]  pat,
  input  logic [4:0]  idx,
  input  logic [15:0] horn_base,
  output logic [15:0] step_hz,
  output logic [15:0] step_ms,
  output logic [4:0]  step_cnt
);
  import bts_pkg::*;

  always_comb begin
    if (pat == PAT_HORN) begin
      // horn: base, rest, base + 40 (wraps at 16 bits)
      priority if (idx == 5'd0) step_hz = horn_base;
      else if (idx == 5'd1)     step_hz = 16'd0;
      else                      step_hz = horn_base + HORN_STEP;
    end else begin
      step_hz = pat_freq(pat, idx);
    end
  end

  assign step_ms  = pat_dur(pat, idx);
  assign step_cnt = pat_len(pat);

endmodule

[src/bts_core.sv]
// Sequencer state and per-word update: tick, single tone, stop, pattern start.
`timescale 1ns / 1ps
`include "buzzer_tone_sequencer_defines.svh"

module bts_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  bts_pkg::bts_req_t req,
  output bts_pkg::bts_res_t res
);
  import bts_pkg::*;

  logic [31:0] tone_deadline_r, tone_deadline_nxt;
  logic        seq_active_r, seq_active_nxt;
  logic [3:0]  pattern_sel_r, pattern_sel_nxt;
  logic [4:0]  step_index_r, step_index_nxt;
  logic [15:0] repeats_left_r, repeats_left_nxt;
  logic [31:0] next_step_time_r, next_step_time_nxt;
  logic [15:0] horn_base_r, horn_base_nxt;
  logic [15:0] drive_freq_r, drive_freq_nxt;

  logic [3:0]  cur_pat;
  logic [4:0]  play_idx;
  logic        exhausted;
  logic [15:0] step_hz;
  logic [15:0] step_ms;
  logic [4:0]  step_cnt;

  assign cur_pat   = (pattern_sel_r > PAT_LAST) ? PAT_HORN : pattern_sel_r;
  assign exhausted = (step_index_r >= step_cnt);
  // table end with repeats left restarts at step 0
  assign play_idx  = (exhausted || step_index_r >= MAX_STEPS) ? 5'd0 : step_index_r;

  bts_rom u_rom (
    .pat      (cur_pat),
    .idx      (play_idx),
    .horn_base(horn_base_r),
    .step_hz  (step_hz),
    .step_ms  (step_ms),
    .step_cnt (step_cnt)
  );

  always_comb begin
    tone_deadline_nxt  = tone_deadline_r;
    seq_active_nxt     = seq_active_r;
    pattern_sel_nxt    = pattern_sel_r;
    step_index_nxt     = step_index_r;
    repeats_left_nxt   = repeats_left_r;
    next_step_time_nxt = next_step_time_r;
    horn_base_nxt      = horn_base_r;
    drive_freq_nxt     = drive_freq_r;

    unique case (req.req_type)
      REQ_TICK: begin
        if (tone_deadline_r != 32'd0 && req.now_ms >= tone_deadline_r) begin
          drive_freq_nxt    = 16'd0;
          tone_deadline_nxt = 32'd0;
        end
        if (seq_active_r && req.now_ms >= next_step_time_r) begin
          if (exhausted && repeats_left_r <= 16'd1) begin
            drive_freq_nxt = 16'd0;
            seq_active_nxt = 1'b0;
          end else begin
            if (exhausted) repeats_left_nxt = repeats_left_r - 16'd1;
            drive_freq_nxt     = step_hz;
            next_step_time_nxt = req.now_ms + {16'd0, step_ms};
            step_index_nxt     = play_idx + 5'd1;
          end
        end
      end
      REQ_TONE: begin
        seq_active_nxt     = 1'b0;
        step_index_nxt     = 5'd0;
        repeats_left_nxt   = 16'd0;
        next_step_time_nxt = 32'd0;
        drive_freq_nxt     = req.tone_hz;
        tone_deadline_nxt  = (req.tone_ms == 16'd0) ? 32'd0
                           : req.now_ms + {16'd0, req.tone_ms};
      end
      REQ_STOP: begin
        tone_deadline_nxt = 32'd0;
        drive_freq_nxt    = 16'd0;
      end
      REQ_START: begin
        if (req.pattern_id <= PAT_LAST) begin
          seq_active_nxt     = 1'b1;
          pattern_sel_nxt    = req.pattern_id;
          step_index_nxt     = 5'd0;
          repeats_left_nxt   = (req.pattern_id <= PAT_SIREN) ? req.repeat_count : 16'd1;
          next_step_time_nxt = 32'd0;
          tone_deadline_nxt  = 32'd0;
          if (req.pattern_id == PAT_HORN) horn_base_nxt = req.base_hz;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_deadline_r  <= 32'd0;
      seq_active_r     <= 1'b0;
      pattern_sel_r    <= 4'd0;
      step_index_r     <= 5'd0;
      repeats_left_r   <= 16'd0;
      next_step_time_r <= 32'd0;
      horn_base_r      <= 16'd0;
      drive_freq_r     <= 16'd0;
    end else if (fire) begin
      tone_deadline_r  <= tone_deadline_nxt;
      seq_active_r     <= seq_active_nxt;
      pattern_sel_r    <= pattern_sel_nxt;
      step_index_r     <= step_index_nxt;
      repeats_left_r   <= repeats_left_nxt;
      next_step_time_r <= next_step_time_nxt;
      horn_base_r      <= horn_base_nxt;
      drive_freq_r     <= drive_freq_nxt;
    end
  end

  assign res.drive_hz      = drive_freq_nxt;
  assign res.sequence_busy = seq_active_nxt;

  `BTS_ASSERT(a_step_range, step_index_r <= MAX_STEPS, "step index past table end")
  `BTS_ASSERT(a_sel_range, pattern_sel_r <= PAT_LAST, "pattern select out of range")
  `BTS_ASSERT_NEXT(a_tone_cancels, fire && req.req_type == REQ_TONE,
                   !seq_active_r && drive_freq_r == $past(req.tone_hz),
                   "single tone did not take over")
  `BTS_ASSERT_NEXT(a_stop_silent, fire && req.req_type == REQ_STOP,
                   drive_freq_r == 16'd0 && tone_deadline_r == 32'd0,
                   "stop left buzzer driven")

endmodule

[src/buzzer_tone_sequencer.sv]
// Buzzer tone sequencer top: input word register, update logic, result register.
// Word path: input word register, then result register, then out_*.
// Throughput: one word per cycle; input stalls only while both registers hold
// a word and out_ready is low.
// Reset (synchronous, rst_n low): buzzer silent, no pattern, no deadline,
// both pipeline registers empty.
`timescale 1ns / 1ps

module buzzer_tone_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_now_ms,
  input  logic [15:0] in_tone_hz,
  input  logic [15:0] in_tone_ms,
  input  logic [3:0]  in_pattern_id,
  input  logic [15:0] in_repeat_count,
  input  logic [15:0] in_base_hz,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_drive_hz,
  output logic        out_sequence_busy
);
  import bts_pkg::*;

  bts_req_t req_r;
  logic     req_vld_r;
  bts_res_t res_r;
  logic     res_vld_r;
  bts_res_t core_res;
  logic     res_load;

  // the buffered word moves on whenever the result register is free or draining
  assign res_load = req_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !req_vld_r || !res_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) req_vld_r <= 1'b1;
      else if (res_load)        req_vld_r <= 1'b0;
      if (res_load)       res_vld_r <= 1'b1;
      else if (out_ready) res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.req_type     <= in_req_type;
      req_r.now_ms       <= in_now_ms;
      req_r.tone_hz      <= in_tone_hz;
      req_r.tone_ms      <= in_tone_ms;
      req_r.pattern_id   <= in_pattern_id;
      req_r.repeat_count <= in_repeat_count;
      req_r.base_hz      <= in_base_hz;
    end
    if (res_load) res_r <= core_res;
  end

  bts_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (res_load),
    .req  (req_r),
    .res  (core_res)
  );

  assign out_valid         = res_vld_r;
  assign out_drive_hz      = res_r.drive_hz;
  assign out_sequence_busy = res_r.sequence_busy;

endmodule

[tb/tb_buzzer_tone_sequencer.sv]
// Testbench for the buzzer tone sequencer: directed table, then random request traffic.
`timescale 1ns / 1ps

module tb_buzzer_tone_sequencer;
  import bts_pkg::*;

  localparam logic [3:0] PAT_BAD        = 4'd15;

  localparam int RAND_WORDS = 950;
  localparam int QUIET_TAIL = 100;
  localparam int WATCHDOG   = 1000;

  typedef struct {
    bts_req_t w;
    bit       typed;
    bts_res_t want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_req_type;
  logic [31:0] in_now_ms;
  logic [15:0] in_tone_hz;
  logic [15:0] in_tone_ms;
  logic [3:0]  in_pattern_id;
  logic [15:0] in_repeat_count;
  logic [15:0] in_base_hz;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [15:0] out_drive_hz;
  logic        out_sequence_busy;

  // predicted buzzer state
  logic [31:0] deadline_ms;
  logic        pat_on;
  logic [3:0]  pat_cur;
  logic [4:0]  step_pos;
  logic [15:0] reps_left;
  logic [31:0] step_due_ms;
  logic [15:0] horn_hz;
  logic [15:0] buzz_hz;

  bts_res_t    expected_q[$];
  step_row_t   dir_rows[$];
  int          err_cnt = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;
  bit          stall_on = 1'b1;
  bit          quiet = 1'b0;
  logic [31:0] clock_ms = 32'd0;

  buzzer_tone_sequencer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_now_ms        (in_now_ms),
    .in_tone_hz       (in_tone_hz),
    .in_tone_ms       (in_tone_ms),
    .in_pattern_id    (in_pattern_id),
    .in_repeat_count  (in_repeat_count),
    .in_base_hz       (in_base_hz),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive_hz     (out_drive_hz),
    .out_sequence_busy(out_sequence_busy)
  );

  always #5 clk = ~clk;

  function automatic logic [4:0] steps_in(input logic [3:0] pat);
    case (pat)
      PAT_HORN:  return 5'd3;
      PAT_SIREN: return 5'd8;
      PAT_CHIRP: return 5'd20;
      PAT_CLICK: return 5'd1;
      default:   return 5'd3;
    endcase
  endfunction

  // Pitch and length of one step of the pattern ROM.
  function automatic void rom_step(input logic [3:0] pat, input logic [4:0] idx,
                                   output logic [15:0] hz, output logic [15:0] ms);
    logic [15:0] chirp_hz [20];
    logic [15:0] chirp_ms [20];
    logic [15:0] hz3 [3];
    logic [15:0] ms3 [3];
    chirp_hz = '{16'd1200, 16'd1400, 16'd1650, 16'd1950, 16'd2250, 16'd0, 16'd2100,
                 16'd1700, 16'd1300, 16'd0, 16'd1000, 16'd1250, 16'd1500, 16'd1750,
                 16'd2100, 16'd0, 16'd2300, 16'd1800, 16'd1400, 16'd1100};
    chirp_ms = '{16'd40, 16'd40, 16'd40, 16'd40, 16'd60, 16'd40, 16'd50, 16'd50,
                 16'd70, 16'd40, 16'd35, 16'd35, 16'd35, 16'd35, 16'd70, 16'd40,
                 16'd45, 16'd45, 16'd55, 16'd80};
    hz3 = '{16'd0, 16'd0, 16'd0};
    ms3 = '{16'd0, 16'd0, 16'd0};
    case (pat)
      PAT_HORN: begin
        hz3 = '{horn_hz, 16'd0, 16'(horn_hz + HORN_STEP)};
        ms3 = '{16'd350, 16'd120, 16'd350};
      end
      PAT_CLICK: begin
        hz3 = '{16'd3000, 16'd0, 16'd0};
        ms3 = '{16'd30, 16'd0, 16'd0};
      end
      PAT_HAPPY: begin
        hz3 = '{16'd800, 16'd1000, 16'd1300};
        ms3 = '{16'd120, 16'd120, 16'd180};
      end
      PAT_SAD: begin
        hz3 = '{16'd700, 16'd0, 16'd500};
        ms3 = '{16'd250, 16'd100, 16'd300};
      end
      PAT_SURPRISE: begin
        hz3 = '{16'd1200, 16'd1600, 16'd1000};
        ms3 = '{16'd100, 16'd120, 16'd140};
      end
      PAT_DISCONNECT: begin
        hz3 = '{16'd900, 16'd0, 16'd700};
        ms3 = '{16'd180, 16'd100, 16'd220};
      end
      PAT_BUTTON: begin
        hz3 = '{16'd2500, 16'd0, 16'd2500};
        ms3 = '{16'd30, 16'd40, 16'd30};
      end
      default: ;
    endcase
    if (pat == PAT_SIREN) begin
      hz = idx[0] ? 16'd0 : 16'd1000;
      ms = 16'd200;
    end else if (pat == PAT_CHIRP) begin
      hz = chirp_hz[idx];
      ms = chirp_ms[idx];
    end else begin
      hz = (idx < 5'd3) ? hz3[idx[1:0]] : 16'd0;
      ms = (idx < 5'd3) ? ms3[idx[1:0]] : 16'd0;
    end
  endfunction

  task automatic reset_state();
    deadline_ms = '0;
    pat_on      = 1'b0;
    pat_cur     = PAT_HORN;
    step_pos    = '0;
    reps_left   = '0;
    step_due_ms = '0;
    horn_hz     = '0;
    buzz_hz     = '0;
  endtask

  task automatic predict_word(input bts_req_t w, output bts_res_t r);
    logic [15:0] hz;
    logic [15:0] ms;
    bit          play;
    case (w.req_type)
      REQ_TICK: begin
        if (deadline_ms != 32'd0 && w.now_ms >= deadline_ms) begin
          buzz_hz     = '0;
          deadline_ms = '0;
        end
        if (pat_on && w.now_ms >= step_due_ms) begin
          play = 1'b1;
          if (step_pos >= steps_in(pat_cur)) begin
            if (reps_left > 16'd1) begin
              reps_left = reps_left - 16'd1;
              step_pos  = '0;
            end else begin
              // table done, no repeat left: falls silent without playing
              buzz_hz = '0;
              pat_on  = 1'b0;
              play    = 1'b0;
            end
          end
          if (play) begin
            rom_step(pat_cur, step_pos, hz, ms);
            buzz_hz     = hz;
            step_due_ms = w.now_ms + {16'd0, ms};
            step_pos    = step_pos + 5'd1;
          end
        end
      end
      REQ_TONE: begin
        pat_on      = 1'b0;
        step_pos    = '0;
        reps_left   = '0;
        step_due_ms = '0;
        buzz_hz     = w.tone_hz;
        // a sum that wraps to zero also means endless
        deadline_ms = (w.tone_ms == 16'd0) ? 32'd0 : w.now_ms + {16'd0, w.tone_ms};
      end
      REQ_STOP: begin
        deadline_ms = '0;
        buzz_hz     = '0;
      end
      default: begin
        if (w.pattern_id <= PAT_LAST) begin
          pat_on      = 1'b1;
          pat_cur     = w.pattern_id;
          step_pos    = '0;
          reps_left   = (w.pattern_id <= PAT_SIREN) ? w.repeat_count : 16'd1;
          step_due_ms = '0;
          deadline_ms = '0;
          if (w.pattern_id == PAT_HORN) horn_hz = w.base_hz;
        end
      end
    endcase
    r.drive_hz      = buzz_hz;
    r.sequence_busy = pat_on;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic add_row(input logic [1:0] req, input logic [31:0] now,
                         input logic [15:0] hz, input logic [15:0] ms,
                         input logic [3:0] pid, input logic [15:0] rep,
                         input logic [15:0] base, input bit typed,
                         input logic [15:0] want_hz, input logic want_busy);
    step_row_t row;
    row.w.req_type           = req;
    row.w.now_ms             = now;
    row.w.tone_hz            = hz;
    row.w.tone_ms            = ms;
    row.w.pattern_id         = pid;
    row.w.repeat_count       = rep;
    row.w.base_hz            = base;
    row.typed                = typed;
    row.want.drive_hz        = want_hz;
    row.want.sequence_busy   = want_busy;
    dir_rows.push_back(row);
  endtask

  // Drive one word, hold it until taken, then queue its expected result.
  task automatic send_word(input bts_req_t w, input bit typed, input bts_res_t want);
    bts_res_t pred;
    if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= w.req_type;
    in_now_ms       <= w.now_ms;
    in_tone_hz      <= w.tone_hz;
    in_tone_ms      <= w.tone_ms;
    in_pattern_id   <= w.pattern_id;
    in_repeat_count <= w.repeat_count;
    in_base_hz      <= w.base_hz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(w, pred);
    expected_q.push_back(typed ? want : pred);
  endtask

  // Mostly plausible request streams; ticks aim at step and deadline edges.
  task automatic make_word(output bts_req_t w);
    int unsigned pick;
    int unsigned aim;
    w.req_type     = 2'($urandom);
    w.now_ms       = $urandom;
    w.tone_hz      = 16'($urandom);
    w.tone_ms      = 16'($urandom);
    w.pattern_id   = 4'($urandom);
    w.repeat_count = 16'($urandom);
    w.base_hz      = 16'($urandom);
    if ($urandom_range(0, 99) == 0) clock_ms = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // fully random word
    end else if (pick < 14) begin
      w.req_type = REQ_TONE;
      w.now_ms   = clock_ms;
      if ($urandom_range(0, 3) != 0) w.tone_ms = 16'($urandom_range(0, 400));
    end else if (pick < 19) begin
      w.req_type = REQ_STOP;
      w.now_ms   = clock_ms;
    end else if (pick < 30) begin
      w.req_type   = REQ_START;
      w.now_ms     = clock_ms;
      w.pattern_id = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 8));
      if ($urandom_range(0, 9) != 0) w.repeat_count = 16'($urandom_range(0, 3));
    end else begin
      w.req_type = REQ_TICK;
      aim = $urandom_range(0, 5);
      if (pat_on && aim <= 1)
        w.now_ms = step_due_ms;
      else if (pat_on && aim == 2)
        w.now_ms = step_due_ms - 32'd1;
      else if (deadline_ms != 32'd0 && aim == 3)
        w.now_ms = deadline_ms - $urandom_range(0, 1);
      else
        w.now_ms = clock_ms + $urandom_range(0, 260);
      clock_ms = w.now_ms;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 19) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 149) == 0) stall_on <= ~stall_on;
    end
  end

  always @(posedge clk) begin
    bts_res_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("word with nothing pending, drive_hz", {16'd0, out_drive_hz},
                          32'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_drive_hz !== e.drive_hz)
            report_mismatch("drive_hz", {16'd0, out_drive_hz}, {16'd0, e.drive_hz});
          if (out_sequence_busy !== e.sequence_busy)
            report_mismatch("sequence_busy", {31'd0, out_sequence_busy},
                            {31'd0, e.sequence_busy});
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    bts_req_t w;
    bts_res_t none;
    int       n_done;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_req_type     = REQ_TICK;
    in_now_ms       = '0;
    in_tone_hz      = '0;
    in_tone_ms      = '0;
    in_pattern_id   = PAT_HORN;
    in_repeat_count = '0;
    in_base_hz      = '0;
    none            = '0;
    n_done          = 0;
    reset_state();

    // req, now, hz, ms, pattern, repeats, base, typed, want hz, want busy
    add_row(REQ_TICK,  32'd0,          16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b1, 16'd0, 1'b0);
    add_row(REQ_TONE,  32'd100,        16'hFFFF,  16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b1, 16'hFFFF, 1'b0);
    add_row(REQ_TICK,  32'hFFFF_FFFF,  16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b1, 16'hFFFF, 1'b0);
    add_row(REQ_TONE,  32'hFFFF_0001,  16'd1234,  16'hFFFF,  PAT_HORN, 16'd0, 16'd0,
            1'b1, 16'd1234, 1'b0);
    add_row(REQ_TICK,  32'hFFFF_FFFF,  16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_TONE,  32'd1000,       16'd500,   16'd10,    PAT_HORN, 16'd0, 16'd0,
            1'b1, 16'd500, 1'b0);
    add_row(REQ_TICK,  32'd1009,       16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_TICK,  32'd1010,       16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_TONE,  32'd1100,       16'd777,   16'd50,    PAT_HORN, 16'd0, 16'd0,
            1'b1, 16'd777, 1'b0);
    // horn with zero repeats and a top base pitch that wraps on the third note
    add_row(REQ_START, 32'd1120,       16'd0,     16'd0,     PAT_HORN, 16'd0, 16'hFFFF,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_TICK,  32'd1200,       16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_TICK,  32'd1549,       16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_TICK,  32'd1550,       16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_TICK,  32'd1670,       16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_STOP,  32'd1700,       16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b1, 16'd0, 1'b1);
    add_row(REQ_TICK,  32'd2020,       16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_START, 32'd2100,       16'd0,     16'd0,     PAT_BAD,  16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_START, 32'd2200,       16'd0,     16'd0,     PAT_SIREN, 16'hFFFF, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_TICK,  32'd2200,       16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_TONE,  32'd2201,       16'd0,     16'd1,     PAT_HORN, 16'd0, 16'd0,
            1'b1, 16'd0, 1'b0);
    add_row(REQ_START, 32'd3000,       16'd0,     16'd0,     PAT_CLICK, 16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_TICK,  32'd3000,       16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_TICK,  32'd3030,       16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_START, 32'd4000,       16'd0,     16'd0,     PAT_CHIRP, 16'd5, 16'd0,
            1'b0, 16'd0, 1'b0);
    add_row(REQ_TICK,  32'hFFFF_FFFF,  16'd0,     16'd0,     PAT_HORN, 16'd0, 16'd0,
            1'b0, 16'd0, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

    while (n_done < RAND_WORDS) begin
      if (n_done % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      quiet = (n_done >= RAND_WORDS - QUIET_TAIL);
      make_word(w);
      send_word(w, 1'b0, none);
      if (!(w.req_type == REQ_START && w.pattern_id > PAT_LAST)) n_done++;
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[buzzer_tone_sequencer.f]
+incdir+src
src/bts_pkg.sv
src/bts_rom.sv
src/bts_core.sv
src/buzzer_tone_sequencer.sv
tb/tb_buzzer_tone_sequencer.sv
